[rtl/core/vsl_pkg.sv]
`timescale 1ns / 1ps
// vsl_pkg: shared types, widths and helpers for the vector set-length unit
// no dependencies; used by vsl_sqrt, vsl_div_lane and vector_set_length_unit

package vsl_pkg;

  // component format and derived widths
  localparam int CW       = 32;          // component width (Q16.16)
  localparam int RW       = 64;          // root width, sqrt with extra fraction bits
  localparam int G        = RW - CW;     // extra fraction bits of the root
  localparam int SW       = 2 * CW;      // squared length width
  localparam int THR_W    = 16;          // threshold register width
  localparam int LANE_LAT = CW + 3;      // divider lane depth

  localparam logic [THR_W-1:0] THR_RESET = 16'd429;

  // command codes
  localparam logic CMD_XYZ = 1'b0;
  localparam logic CMD_XZ  = 1'b1;

  // saturation limits on the rounded quotient magnitude
  localparam logic [CW:0] POS_LIM = {2'b00, {(CW-1){1'b1}}};
  localparam logic [CW:0] NEG_LIM = {2'b01, {(CW-1){1'b0}}};

  typedef struct packed {
    logic                 command;
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] z_in;
    logic signed [CW-1:0] target_length;
  } vsl_in_t;

  typedef struct packed {
    logic signed [CW-1:0] x_out;
    logic signed [CW-1:0] y_out;
    logic signed [CW-1:0] z_out;
    logic                 degenerate;
  } vsl_out_t;

  typedef struct packed {
    logic planar;
    logic degen;
  } vsl_flags_t;

  // data that rides along the root pipeline
  typedef struct packed {
    vsl_flags_t    flags;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic [CW-1:0] t;
  } vsl_side_t;

  // magnitude of a two's complement component, the most negative value included
  function automatic logic [CW-1:0] mag_of(logic [CW-1:0] v);
    logic [CW-1:0] m;
    m = v[CW-1] ? (~v + 1'b1) : v;
    return m;
  endfunction

endpackage

[rtl/core/vsl_sqrt.sv]
`timescale 1ns / 1ps
// vsl_sqrt: pipelined integer square root, one result bit per stage
// depends on vsl_pkg; computes floor(sqrt(sq * 2^(2G))) over RW stages

module vsl_sqrt import vsl_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [SW-1:0]   in_sq,
  input  vsl_side_t       in_side,
  output logic            out_valid,
  output logic [RW-1:0]   out_root,
  output vsl_side_t       out_side
);

  logic            v_r    [0:RW];
  logic [SW-1:0]   sq_r   [0:RW];
  logic [RW+1:0]   rem_r  [0:RW];
  logic [RW-1:0]   root_r [0:RW];
  vsl_side_t       side_r [0:RW];

  // stage zero is the input
  assign v_r[0]    = in_valid;
  assign sq_r[0]   = in_sq;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign side_r[0] = in_side;

  for (genvar i = 0; i < RW; i++) begin : g_step
    logic [1:0]    pair;
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic          ge;

    // next two radicand bits, the low 2G bits are zero
    if (2*RW - 2 - 2*i >= 2*G) begin : g_bits
      assign pair = sq_r[i][2*RW-2-2*i-2*G +: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    // restoring root digit
    assign rem_sh = {rem_r[i][RW-1:0], pair};
    assign trial  = {root_r[i], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      sq_r[i+1]   <= sq_r[i];
      side_r[i+1] <= side_r[i];
      rem_r[i+1]  <= ge ? (rem_sh - trial) : rem_sh;
      root_r[i+1] <= {root_r[i][RW-2:0], ge};
    end
  end

  assign out_valid = v_r[RW];
  assign out_root  = root_r[RW];
  assign out_side  = side_r[RW];

endmodule

[rtl/core/vsl_div_lane.sv]
`timescale 1ns / 1ps
// vsl_div_lane: one component lane, |c|*|t|*2^G / root with rounding and saturation
// depends on vsl_pkg; pipelined restoring divider, one quotient bit per stage

module vsl_div_lane import vsl_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  vsl_flags_t      in_flags,
  input  logic [CW-1:0]   in_comp,
  input  logic [CW-1:0]   in_tgt,
  input  logic [RW-1:0]   in_root,
  output logic            out_valid,
  output vsl_flags_t      out_flags,
  output logic [CW-1:0]   out_comp,
  output logic [CW-1:0]   out_q
);

  // product stage
  logic            p_v_r;
  logic [SW-1:0]   p_prod_r;
  logic            p_neg_r;
  logic [RW-1:0]   p_root_r;
  vsl_flags_t      p_flags_r;
  logic [CW-1:0]   p_comp_r;
  logic [SW-1:0]   prod_nxt;

  assign prod_nxt = mag_of(in_comp) * mag_of(in_tgt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else begin
      p_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    p_prod_r  <= prod_nxt;
    p_neg_r   <= in_comp[CW-1] ^ in_tgt[CW-1];
    p_root_r  <= in_root;
    p_flags_r <= in_flags;
    p_comp_r  <= in_comp;
  end

  // overflow check: quotient reaches 2^CW when the high part is not below root
  logic [CW+RW-1:0] num;
  assign num = {p_prod_r, {G{1'b0}}};

  logic            d_v_r    [0:CW];
  logic [RW-1:0]   d_rem_r  [0:CW];
  logic [CW-1:0]   d_lo_r   [0:CW];
  logic [CW-1:0]   d_q_r    [0:CW];
  logic [RW-1:0]   d_root_r [0:CW];
  logic            d_neg_r  [0:CW];
  logic            d_ovf_r  [0:CW];
  vsl_flags_t      d_flags_r[0:CW];
  logic [CW-1:0]   d_comp_r [0:CW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r[0] <= 1'b0;
    end else begin
      d_v_r[0] <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    d_rem_r[0]   <= num[CW+RW-1:CW];
    d_lo_r[0]    <= num[CW-1:0];
    d_q_r[0]     <= '0;
    d_root_r[0]  <= p_root_r;
    d_neg_r[0]   <= p_neg_r;
    d_ovf_r[0]   <= (num[CW+RW-1:CW] >= p_root_r);
    d_flags_r[0] <= p_flags_r;
    d_comp_r[0]  <= p_comp_r;
  end

  // quotient bit stages
  for (genvar k = 0; k < CW; k++) begin : g_div
    logic [RW:0] rem_sh;
    logic [RW:0] dvs;
    logic [RW:0] rem_sub;
    logic        ge;

    assign rem_sh  = {d_rem_r[k], d_lo_r[k][CW-1-k]};
    assign dvs     = {1'b0, d_root_r[k]};
    assign ge      = (rem_sh >= dvs);
    assign rem_sub = rem_sh - dvs;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_v_r[k+1] <= 1'b0;
      end else begin
        d_v_r[k+1] <= d_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      d_rem_r[k+1]   <= ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
      d_lo_r[k+1]    <= d_lo_r[k];
      d_q_r[k+1]     <= {d_q_r[k][CW-2:0], ge};
      d_root_r[k+1]  <= d_root_r[k];
      d_neg_r[k+1]   <= d_neg_r[k];
      d_ovf_r[k+1]   <= d_ovf_r[k];
      d_flags_r[k+1] <= d_flags_r[k];
      d_comp_r[k+1]  <= d_comp_r[k];
    end
  end

  // round half away from zero, then saturate
  logic          rnd;
  logic [CW:0]   q_rnd;
  logic          sat;
  logic [CW-1:0] mag;
  logic [CW-1:0] q_nxt;

  always_comb begin
    rnd   = ({d_rem_r[CW], 1'b0} >= {1'b0, d_root_r[CW]});
    q_rnd = {1'b0, d_q_r[CW]} + {{CW{1'b0}}, rnd};
    if (d_neg_r[CW]) begin
      sat = d_ovf_r[CW] || (q_rnd > NEG_LIM);
      mag = sat ? NEG_LIM[CW-1:0] : q_rnd[CW-1:0];
    end else begin
      sat = d_ovf_r[CW] || (q_rnd > POS_LIM);
      mag = sat ? POS_LIM[CW-1:0] : q_rnd[CW-1:0];
    end
    q_nxt = d_neg_r[CW] ? (~mag + 1'b1) : mag;
  end

  logic            o_v_r;
  vsl_flags_t      o_flags_r;
  logic [CW-1:0]   o_comp_r;
  logic [CW-1:0]   o_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else begin
      o_v_r <= d_v_r[CW];
    end
  end

  always_ff @(posedge clk) begin
    o_flags_r <= d_flags_r[CW];
    o_comp_r  <= d_comp_r[CW];
    o_q_r     <= q_nxt;
  end

  assign out_valid = o_v_r;
  assign out_flags = o_flags_r;
  assign out_comp  = o_comp_r;
  assign out_q     = o_q_r;

endmodule

[rtl/core/vector_set_length_unit.sv]
`timescale 1ns / 1ps
// Vector set-length unit: rescales a signed Q16.16 vector to a requested length,
// full xyz or xz plane only, with a degenerate check on the squared length.
// The unit takes one vector every clock cycle and never raises busy. Each
// result appears on out_data for one cycle with out_valid high, once its
// start transfer has passed three front stages (input, squares, sum and
// threshold compare), a 64-stage root pipeline, then three parallel
// 35-stage divider lanes and a merge register.
// The receiver cannot stall, so every result must be taken in its cycle.
// Depends on vsl_pkg, vsl_sqrt and vsl_div_lane.

module vector_set_length_unit import vsl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  vsl_in_t           in_data,
  output logic              out_valid,
  output vsl_out_t          out_data,
  input  logic              cfg_we,
  input  logic [THR_W-1:0]  cfg_data
);

  localparam int LATENCY = 3 + RW + LANE_LAT + 1;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // threshold register
  logic [THR_W-1:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_data;
    end
  end

  // input register
  logic    in_v_r;
  vsl_in_t in_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= accept;
    end
  end
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
  end

  // squares of the taking-part components
  logic          planar;
  logic          sq_v_r;
  logic [SW-1:0] xx_r, yy_r, zz_r;
  vsl_in_t       sq_in_r;
  logic [CW-1:0] mx, my, mz;

  assign planar = (in_r.command == CMD_XZ);
  assign mx = mag_of(in_r.x_in);
  assign my = planar ? '0 : mag_of(in_r.y_in);
  assign mz = mag_of(in_r.z_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else begin
      sq_v_r <= in_v_r;
    end
  end
  always_ff @(posedge clk) begin
    xx_r    <= mx * mx;
    yy_r    <= my * my;
    zz_r    <= mz * mz;
    sq_in_r <= in_r;
  end

  // squared length and degenerate test
  logic          sum_v_r;
  logic [SW-1:0] sum_nxt, sum_r;
  vsl_side_t     side_nxt, side_r;

  always_comb begin
    sum_nxt               = xx_r + yy_r + zz_r;
    side_nxt.flags.planar = (sq_in_r.command == CMD_XZ);
    side_nxt.flags.degen  = (sum_nxt == '0) ||
                            (sum_nxt < {{(SW-THR_W){1'b0}}, thr_r});
    side_nxt.x            = sq_in_r.x_in;
    side_nxt.y            = sq_in_r.y_in;
    side_nxt.z            = sq_in_r.z_in;
    side_nxt.t            = sq_in_r.target_length;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r <= 1'b0;
    end else begin
      sum_v_r <= sq_v_r;
    end
  end
  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    side_r <= side_nxt;
  end

  // root pipeline
  logic          rt_valid;
  logic [RW-1:0] rt_root;
  vsl_side_t     rt_side;

  vsl_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sum_v_r),
    .in_sq     (sum_r),
    .in_side   (side_r),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  // three component lanes
  logic          vx, vy, vz;
  vsl_flags_t    fx, fy, fz;
  logic [CW-1:0] cx, cy, cz;
  logic [CW-1:0] qx, qy, qz;

  vsl_div_lane u_lane_x (
    .clk(clk), .rst_n(rst_n), .in_valid(rt_valid), .in_flags(rt_side.flags),
    .in_comp(rt_side.x), .in_tgt(rt_side.t), .in_root(rt_root),
    .out_valid(vx), .out_flags(fx), .out_comp(cx), .out_q(qx)
  );

  vsl_div_lane u_lane_y (
    .clk(clk), .rst_n(rst_n), .in_valid(rt_valid), .in_flags(rt_side.flags),
    .in_comp(rt_side.y), .in_tgt(rt_side.t), .in_root(rt_root),
    .out_valid(vy), .out_flags(fy), .out_comp(cy), .out_q(qy)
  );

  vsl_div_lane u_lane_z (
    .clk(clk), .rst_n(rst_n), .in_valid(rt_valid), .in_flags(rt_side.flags),
    .in_comp(rt_side.z), .in_tgt(rt_side.t), .in_root(rt_root),
    .out_valid(vz), .out_flags(fz), .out_comp(cz), .out_q(qz)
  );

  // merge: degenerate vectors and planar y pass through unchanged
  logic     out_v_r;
  vsl_out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= vx && vy && vz;
    end
  end
  always_ff @(posedge clk) begin
    out_r.x_out      <= fx.degen ? cx : qx;
    out_r.y_out      <= (fx.degen || fx.planar) ? cy : qy;
    out_r.z_out      <= fx.degen ? cz : qz;
    out_r.degenerate <= fx.degen;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // lanes stay in lockstep
  a_lane_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (vx == vy) && (vx == vz))
    else $error("divider lanes out of step");

  a_lane_flags: assert property (@(posedge clk) disable iff (!rst_n)
    vx |-> (fx == fy) && (fx == fz))
    else $error("divider lanes disagree on flags");

  // each start transfer yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("result missing after start transfer");

  // no front pipeline valid without a start transfer at the matching time
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    sum_v_r |-> $past(accept, 3))
    else $error("front pipeline valid without a transfer");

endmodule
